>>> rtl/core/mrvc_pkg.sv
// shared types, constants and tables of the meter range value converter
package mrvc_pkg;

  // window length of the ac peak detector
  localparam int unsigned AcWindow = 200;

  // range codes
  localparam logic [3:0] RANGE_V200   = 4'd0;
  localparam logic [3:0] RANGE_V20    = 4'd1;
  localparam logic [3:0] RANGE_V4     = 4'd2;
  localparam logic [3:0] RANGE_MV800  = 4'd3;
  localparam logic [3:0] RANGE_MV200  = 4'd4;
  localparam logic [3:0] RANGE_A1     = 4'd5;
  localparam logic [3:0] RANGE_A50M   = 4'd6;
  localparam logic [3:0] RANGE_A10M   = 4'd7;
  localparam logic [3:0] RANGE_R1M    = 4'd8;
  localparam logic [3:0] RANGE_R50K   = 4'd9;
  localparam logic [3:0] RANGE_R1K    = 4'd10;

  // configuration register indexes
  localparam logic [3:0] CFG_RANGE_SELECT = 4'd0;
  localparam logic [3:0] CFG_AC_MODE      = 4'd1;
  localparam logic [3:0] CFG_RATIO_HIGH   = 4'd2;
  localparam logic [3:0] CFG_RATIO_MID    = 4'd3;

  localparam logic [63:0] ValCap     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] AutoThresh = 64'd200000000;
  localparam logic [22:0] DivFull    = 23'd4950000;

  typedef struct packed {
    logic [22:0] sample_uv;
    logic        sign_negative;
    logic        stop_window;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] value_micro;
    logic [3:0]         active_range;
    logic               out_of_limits;
    logic               range_switched;
    logic               saturated;
  } out_res_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  index;
    logic [23:0] data;
  } cfg_req_t;

  // low limit per range in micro-units
  function automatic logic [41:0] lim_lo(input logic [3:0] r);
    case (r)
      RANGE_V200:  lim_lo = 42'd20000000;
      RANGE_V20:   lim_lo = 42'd4000000;
      RANGE_V4:    lim_lo = 42'd800000;
      RANGE_MV800: lim_lo = 42'd1000000;
      RANGE_MV200: lim_lo = 42'd1000000;
      RANGE_A1:    lim_lo = 42'd50000;
      RANGE_A50M:  lim_lo = 42'd10000;
      RANGE_A10M:  lim_lo = 42'd1000;
      RANGE_R1M:   lim_lo = 42'd50000000000;
      RANGE_R50K:  lim_lo = 42'd1000000000;
      default:     lim_lo = 42'd400000000;
    endcase
  endfunction

  // high limit per range in micro-units
  function automatic logic [41:0] lim_hi(input logic [3:0] r);
    case (r)
      RANGE_V200:  lim_hi = 42'd200000000;
      RANGE_V20:   lim_hi = 42'd20000000;
      RANGE_V4:    lim_hi = 42'd4000000;
      RANGE_MV800: lim_hi = 42'd800000000;
      RANGE_MV200: lim_hi = 42'd800000000;
      RANGE_A1:    lim_hi = 42'd1000000;
      RANGE_A50M:  lim_hi = 42'd50000;
      RANGE_A10M:  lim_hi = 42'd10000;
      RANGE_R1M:   lim_hi = 42'd3000000000000;
      RANGE_R50K:  lim_hi = 42'd50000000000;
      default:     lim_hi = 42'd1000000000;
    endcase
  endfunction

  // divider reference constant of the resistance ranges
  function automatic logic [19:0] div_k(input logic [3:0] r);
    case (r)
      RANGE_R1M:  div_k = 20'd940180;
      RANGE_R50K: div_k = 20'd18220;
      default:    div_k = 20'd700;
    endcase
  endfunction

endpackage

>>> rtl/core/mrvc_front.sv
// front end: input request register queue feeding the back end
module mrvc_front import mrvc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    q_valid_o,
  input  logic    q_pop_i,
  output in_req_t q_req_o
);

  in_req_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // two-entry queue between front and back
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_req_i;
    end
  end

endmodule

>>> rtl/core/mrvc_div.sv
// serial restoring divider, one quotient bit per cycle
module mrvc_div import mrvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [22:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] q_q, q_d;
  logic [23:0] rem_q, rem_d;
  logic [22:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [23:0] rem_sh;
  logic        fits;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_sh = {rem_q[22:0], q_q[63]};
    fits   = (rem_sh >= {1'b0, dvs_q});
    rem_d  = rem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = 24'd0;
      q_d    = dividend_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      q_d   = {q_q[62:0], fits};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

>>> rtl/core/mrvc_back.sv
// back end: range scaling, resistance formula, ac peak, auto-ranging and limits
module mrvc_back import mrvc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_req_t cfg_i,
  input  logic     q_valid_i,
  output logic     q_pop_o,
  input  in_req_t  q_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCALE  = 4'd1;
  localparam logic [3:0] ST_R_MHI  = 4'd2;
  localparam logic [3:0] ST_R_MLO  = 4'd3;
  localparam logic [3:0] ST_R_DIV  = 4'd4;
  localparam logic [3:0] ST_CAL_HI = 4'd5;
  localparam logic [3:0] ST_CAL_LO = 4'd6;
  localparam logic [3:0] ST_C_DIV  = 4'd7;
  localparam logic [3:0] ST_POST   = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  // reciprocals: ceil(2^28/25), ceil(2^40/1000), ceil(2^44/10000)
  localparam logic [23:0] Recip25  = 24'd10737419;
  localparam logic [30:0] Recip1k  = 31'd1099511628;
  localparam logic [30:0] Recip10k = 31'd1759218605;

  logic [3:0]  state_q, state_d;
  logic [3:0]  range_sel_q;
  logic        ac_mode_q;
  logic [23:0] ratio_high_q, ratio_mid_q;
  logic [3:0]  cur_range_q, cur_range_d;
  logic [47:0] peak_q, peak_d;
  logic [7:0]  win_cnt_q, win_cnt_d;

  in_req_t     item_q;
  logic [63:0] m_q, m_d;
  logic [63:0] acc_q, acc_d;
  logic [42:0] p_q, p_d;
  logic [22:0] d_q, d_d;
  logic [13:0] coef_q, coef_d;
  logic        cdiv_q, cdiv_d;
  logic [34:0] offs_q, offs_d;
  logic        sat_q, sat_d;
  logic        neg_q, neg_d;
  logic [63:0] cnum_q, cnum_d;
  logic [13:0] crem_q, crem_d;
  logic [15:0] cdig_q, cdig_d;
  logic [2:0]  cstep_q, cstep_d;

  out_res_t    res_q, res_d;
  logic        out_valid_q, out_valid_d;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [22:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quot;

  logic [3:0]  r;
  logic [23:0] ratio;
  logic [47:0] scaled_prod;
  logic [23:0] a_num;
  logic [22:0] a_pre;
  logic [46:0] a_prod;
  logic [29:0] c_t;
  logic [30:0] c_recip;
  logic [13:0] c_dvs;
  logic [60:0] c_prod;
  logic [15:0] c_digit;
  logic [29:0] c_rem_full;
  logic [63:0] newpeak;
  logic [7:0]  cnt_inc;
  logic        out_free;
  logic        sw;
  logic [63:0] m_clip;
  logic        clip;
  logic [47:0] mag48;
  logic        cfg_range_ok;

  assign r        = cur_range_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign ratio    = (r == RANGE_V200) ? ratio_high_q : ratio_mid_q;
  assign scaled_prod = {1'b0, 47'({24'd0, item_q.sample_uv} * {23'd0, ratio})} + 48'd32768;
  assign newpeak  = (m_q > {16'd0, peak_q}) ? m_q : {16'd0, peak_q};
  assign cnt_inc  = win_cnt_q + 8'd1;
  assign cfg_range_ok = (cfg_i.data[3:0] <= RANGE_R1K);

  // 50m and 10m current ranges: halve or divide by 8, then divide by 25 via reciprocal
  assign a_num  = {1'b0, item_q.sample_uv} + ((r == RANGE_A50M) ? 24'd25 : 24'd100);
  assign a_pre  = (r == RANGE_A50M) ? a_num[23:1] : {2'd0, a_num[23:3]};
  assign a_prod = 47'({24'd0, a_pre} * {23'd0, Recip25});

  // one 16-bit quotient digit of the calibration division by 1000 or 10000
  assign c_t        = {crem_q, cnum_q[63:48]};
  assign c_recip    = cdiv_q ? Recip10k : Recip1k;
  assign c_dvs      = cdiv_q ? 14'd10000 : 14'd1000;
  assign c_prod     = 61'(c_t * c_recip);
  assign c_digit    = cdiv_q ? c_prod[59:44] : c_prod[55:40];
  assign c_rem_full = c_t - 30'(cdig_q * c_dvs);

  // serial divider for the resistance divider formula
  assign div_start    = (state_q == ST_R_MLO);
  assign div_dividend = acc_q + 64'(p_q[20:0] * 20'd1000000) + {42'd0, d_q[22:1]};
  assign div_divisor  = d_q;

  mrvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // final checks: auto-ranging, clipping, limits
  always_comb begin
    sw = ((r == RANGE_MV800) && (m_q < AutoThresh))
      || ((r == RANGE_MV200) && (m_q >= AutoThresh));
    clip   = (m_q > ValCap);
    m_clip = clip ? ValCap : m_q;
    mag48  = m_clip[47:0];
    res_d.value_micro    = neg_q ? (48'd0 - mag48) : mag48;
    res_d.active_range   = r;
    res_d.out_of_limits  = (m_clip != 64'd0)
      && ((m_clip < {22'd0, lim_lo(range_sel_q)}) || (m_clip > {22'd0, lim_hi(range_sel_q)}));
    res_d.range_switched = sw;
    res_d.saturated      = sat_q || clip;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    acc_d       = acc_q;
    p_d         = p_q;
    d_d         = d_q;
    coef_d      = coef_q;
    cdiv_d      = cdiv_q;
    offs_d      = offs_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    cnum_d      = cnum_q;
    crem_d      = crem_q;
    cdig_d      = cdig_q;
    cstep_d     = cstep_q;
    cur_range_d = cur_range_q;
    peak_d      = peak_q;
    win_cnt_d   = win_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_SCALE;
          sat_d   = 1'b0;
          neg_d   = 1'b0;
        end
      end
      ST_SCALE: begin
        state_d = ST_POST;
        case (r)
          RANGE_V200, RANGE_V20: m_d = {32'd0, scaled_prod[47:16]};
          RANGE_MV800: m_d = 64'({41'd0, item_q.sample_uv} * 64'd200);
          RANGE_MV200: m_d = 64'({41'd0, item_q.sample_uv} * 64'd50);
          RANGE_A50M, RANGE_A10M: m_d = {45'd0, a_prod[46:28]};
          RANGE_R1M, RANGE_R50K, RANGE_R1K: begin
            if (item_q.sample_uv >= DivFull) begin
              m_d     = ValCap;
              sat_d   = 1'b1;
              state_d = ST_FIN;
            end else begin
              p_d     = 43'(item_q.sample_uv * div_k(r));
              d_d     = DivFull - item_q.sample_uv;
              state_d = ST_R_MHI;
            end
          end
          default: m_d = {41'd0, item_q.sample_uv};
        endcase
      end
      ST_R_MHI: begin
        acc_d   = {1'b0, 42'(p_q[42:21] * 20'd1000000), 21'd0};
        state_d = ST_R_MLO;
      end
      ST_R_MLO: begin
        state_d = ST_R_DIV;
      end
      ST_R_DIV: begin
        if (div_done) begin
          m_d = div_quot;
          if (div_quot > ValCap) begin
            m_d     = ValCap;
            sat_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_CAL_HI;
          end
        end
      end
      ST_CAL_HI: begin
        // pick calibration line for the range
        if (r == RANGE_R1M) begin
          coef_d = 14'd1007; cdiv_d = 1'b0; offs_d = 35'd20430000000;
        end else if (r == RANGE_R50K) begin
          coef_d = 14'd9985; cdiv_d = 1'b1; offs_d = 35'd560500000;
        end else if (m_q > 64'd400000000) begin
          coef_d = 14'd9359; cdiv_d = 1'b1; offs_d = 35'd46270000;
        end else begin
          coef_d = 14'd964;  cdiv_d = 1'b0; offs_d = 35'd17800000;
        end
        acc_d   = {3'd0, 37'(m_q[46:24] * coef_d), 24'd0};
        state_d = ST_CAL_LO;
      end
      ST_CAL_LO: begin
        cnum_d  = acc_q + 64'(m_q[23:0] * coef_q) + (cdiv_q ? 64'd5000 : 64'd500);
        crem_d  = 14'd0;
        cstep_d = 3'd0;
        state_d = ST_C_DIV;
      end
      ST_C_DIV: begin
        // even steps form a digit, odd steps take the remainder and shift it in
        cstep_d = cstep_q + 3'd1;
        if (!cstep_q[0]) begin
          cdig_d = c_digit;
        end else begin
          crem_d = c_rem_full[13:0];
          cnum_d = {cnum_q[47:0], cdig_q};
          if (cstep_q == 3'd7) begin
            m_d     = {cnum_q[47:0], cdig_q} + {29'd0, offs_q};
            state_d = ST_FIN;
          end
        end
      end
      ST_POST: begin
        state_d = ST_FIN;
        if (ac_mode_q) begin
          if (!item_q.stop_window && ({24'd0, cnt_inc} < AcWindow)) begin
            peak_d    = newpeak[47:0];
            win_cnt_d = cnt_inc;
            state_d   = ST_IDLE;
          end else begin
            m_d       = newpeak;
            peak_d    = 48'd0;
            win_cnt_d = 8'd0;
          end
        end else begin
          neg_d = (r <= RANGE_V20) ? item_q.sign_negative : !item_q.sign_negative;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sw) begin
            cur_range_d = (r == RANGE_MV800) ? RANGE_MV200 : RANGE_MV800;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // valid range writes reload the range; range and mode writes clear the ac window
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RANGE_SELECT: begin
          if (cfg_range_ok) begin
            cur_range_d = cfg_i.data[3:0];
            peak_d      = 48'd0;
            win_cnt_d   = 8'd0;
          end
        end
        CFG_AC_MODE: begin
          peak_d    = 48'd0;
          win_cnt_d = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      range_sel_q  <= RANGE_V200;
      ac_mode_q    <= 1'b0;
      ratio_high_q <= 24'd65536;
      ratio_mid_q  <= 24'd65536;
      cur_range_q  <= RANGE_V200;
      peak_q       <= 48'd0;
      win_cnt_q    <= 8'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_range_q <= cur_range_d;
      peak_q      <= peak_d;
      win_cnt_q   <= win_cnt_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_RANGE_SELECT: begin
            if (cfg_range_ok) begin
              range_sel_q <= cfg_i.data[3:0];
            end
          end
          CFG_AC_MODE:    ac_mode_q    <= cfg_i.data[0];
          CFG_RATIO_HIGH: ratio_high_q <= cfg_i.data;
          CFG_RATIO_MID:  ratio_mid_q  <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_req_i;
    end
    m_q     <= m_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    d_q     <= d_d;
    coef_q  <= coef_d;
    cdiv_q  <= cdiv_d;
    offs_q  <= offs_d;
    sat_q   <= sat_d;
    neg_q   <= neg_d;
    cnum_q  <= cnum_d;
    crem_q  <= crem_d;
    cdig_q  <= cdig_d;
    cstep_q <= cstep_d;
    if (state_q == ST_FIN && out_free) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> rtl/core/meter_range_value_converter.sv
// top level of the meter range value converter
// A two-entry request queue takes samples while the back end works; the back end
// handles one request at a time, taking it from the queue in the cycle after it
// arrives when idle. Voltage and current ranges pass through scale, post and final
// states. Resistance ranges run the 64-step serial divider of the divider formula
// plus an 8-step reciprocal division for the calibration line; a sample at or
// above the divider limit saturates without either division. In ac mode a sample
// inside the window gives no result. The result sits in an output register, so
// the next request is worked on while it waits, up to its last step.
// Configuration writes are always ready and belong in idle periods only.
module meter_range_value_converter import mrvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_res_t    out_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic     q_valid;
  logic     q_pop;
  in_req_t  q_req;
  cfg_req_t cfg;

  // configuration request bundle
  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  mrvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  mrvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

>>> sim/meter_range_value_converter_tb.sv
// testbench of the meter range value converter: directed and random samples against a predictor
`timescale 1ns / 100ps

module meter_range_value_converter_tb;
  import mrvc_pkg::*;

  localparam int unsigned DrainCycles = 400;
  localparam int unsigned WatchdogLimit = 20000;
  localparam longint unsigned Cap = 64'h0000_7FFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_req_t     in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_res_t    out_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // shadow of the block's registers and state
  logic [3:0]  sh_range_sel;
  logic        sh_ac;
  logic [23:0] sh_ratio_high;
  logic [23:0] sh_ratio_mid;
  logic [3:0]  sh_cur_range;
  longint unsigned sh_peak;
  logic [7:0]  sh_win_count;

  out_res_t pending_vals[$];
  bit       failed = 1'b0;
  bit       idle_on = 1'b1;
  int unsigned quiet_cycles = 0;

  longint unsigned lo_lim[11] = '{64'd20000000, 64'd4000000, 64'd800000, 64'd1000000,
    64'd1000000, 64'd50000, 64'd10000, 64'd1000, 64'd50000000000, 64'd1000000000,
    64'd400000000};
  longint unsigned hi_lim[11] = '{64'd200000000, 64'd20000000, 64'd4000000, 64'd800000000,
    64'd800000000, 64'd1000000, 64'd50000, 64'd10000, 64'd3000000000000,
    64'd50000000000, 64'd1000000000};

  meter_range_value_converter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i, .out_valid_o, .out_stall_i,
    .out_res_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // magnitude of a voltage or current sample in one range
  function automatic longint unsigned scaled_mag(logic [3:0] r, longint unsigned s);
    case (r)
      RANGE_V200:  return (s * sh_ratio_high + 64'd32768) >> 16;
      RANGE_V20:   return (s * sh_ratio_mid + 64'd32768) >> 16;
      RANGE_MV800: return 64'd200 * s;
      RANGE_MV200: return 64'd50 * s;
      RANGE_A50M:  return (s + 64'd25) / 64'd50;
      RANGE_A10M:  return (s + 64'd100) / 64'd200;
      default:     return s;
    endcase
  endfunction

  // divider formula and linear calibration of the resistance ranges
  function automatic longint unsigned ohms_mag(logic [3:0] r, longint unsigned s,
                                               ref bit sat);
    longint unsigned d, rm, k;
    if (s >= 64'd4950000) begin
      sat = 1'b1;
      return Cap;
    end
    d = 64'd4950000 - s;
    k = (r == RANGE_R1M) ? 64'd940180 : (r == RANGE_R50K) ? 64'd18220 : 64'd700;
    rm = (s * k * 64'd1000000 + d / 2) / d;
    if (rm > Cap) begin
      sat = 1'b1;
      return Cap;
    end
    if (r == RANGE_R1M) return (rm * 1007 + 500) / 1000 + 64'd20430000000;
    if (r == RANGE_R50K) return (rm * 9985 + 5000) / 10000 + 64'd560500000;
    if (rm > 64'd400000000) return (rm * 9359 + 5000) / 10000 + 64'd46270000;
    return (rm * 964 + 500) / 1000 + 64'd17800000;
  endfunction

  // expected result of one accepted request, if it causes one
  function automatic bit predict_value(in_req_t q, output out_res_t res);
    longint unsigned s, m;
    logic [3:0] r;
    bit neg, sat, sw;
    s = q.sample_uv;
    r = sh_cur_range;
    neg = 1'b0;
    sat = 1'b0;
    sw = 1'b0;
    res = '0;
    if (r >= RANGE_R1M) begin
      m = ohms_mag(r, s, sat);
    end else if (sh_ac) begin
      m = scaled_mag(r, s);
      if (m > sh_peak) sh_peak = m;
      sh_win_count = sh_win_count + 8'd1;
      if (!q.stop_window && sh_win_count < AcWindow) return 1'b0;
      m = sh_peak;
      sh_peak = 0;
      sh_win_count = '0;
    end else begin
      m = scaled_mag(r, s);
      neg = (r <= RANGE_V20) ? q.sign_negative : !q.sign_negative;
    end
    if (r == RANGE_MV800 && m < 64'd200000000) begin
      sh_cur_range = RANGE_MV200;
      sw = 1'b1;
    end else if (r == RANGE_MV200 && m >= 64'd200000000) begin
      sh_cur_range = RANGE_MV800;
      sw = 1'b1;
    end
    if (m > Cap) begin
      m = Cap;
      sat = 1'b1;
    end
    res.value_micro = neg ? -m[47:0] : m[47:0];
    res.active_range = r;
    res.out_of_limits = (m != 0) && (m < lo_lim[sh_range_sel] || m > hi_lim[sh_range_sel]);
    res.range_switched = sw;
    res.saturated = sat;
    return 1'b1;
  endfunction

  // register write as seen by the block
  function automatic void apply_reg(logic [3:0] idx, logic [23:0] data);
    case (idx)
      CFG_RANGE_SELECT: begin
        if (data[3:0] <= RANGE_R1K) begin
          sh_range_sel = data[3:0];
          sh_cur_range = data[3:0];
          sh_peak = 0;
          sh_win_count = '0;
        end
      end
      CFG_AC_MODE: begin
        sh_ac = data[0];
        sh_peak = 0;
        sh_win_count = '0;
      end
      CFG_RATIO_HIGH: sh_ratio_high = data;
      CFG_RATIO_MID: sh_ratio_mid = data;
      default: ;
    endcase
  endfunction

  // prediction, result check and watchdog
  always @(posedge clk_i) begin
    out_res_t exp_res, got;
    bit busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        busy = 1'b1;
        if (predict_value(in_req_i, exp_res)) pending_vals.push_back(exp_res);
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        got = out_res_o;
        if (pending_vals.size() == 0) begin
          $error("unexpected result, value_micro %0d", got.value_micro);
          failed = 1'b1;
        end else begin
          exp_res = pending_vals.pop_front();
          if (got.value_micro !== exp_res.value_micro) begin
            $error("value_micro expected %0d actual %0d", exp_res.value_micro,
                   got.value_micro);
            failed = 1'b1;
          end
          if (got.active_range !== exp_res.active_range) begin
            $error("active_range expected %0d actual %0d", exp_res.active_range,
                   got.active_range);
            failed = 1'b1;
          end
          if (got.out_of_limits !== exp_res.out_of_limits) begin
            $error("out_of_limits expected %0d actual %0d", exp_res.out_of_limits,
                   got.out_of_limits);
            failed = 1'b1;
          end
          if (got.range_switched !== exp_res.range_switched) begin
            $error("range_switched expected %0d actual %0d", exp_res.range_switched,
                   got.range_switched);
            failed = 1'b1;
          end
          if (got.saturated !== exp_res.saturated) begin
            $error("saturated expected %0d actual %0d", exp_res.saturated, got.saturated);
            failed = 1'b1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        busy = 1'b1;
        apply_reg(cfg_index_i, cfg_data_i);
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // random stall on the result side
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 30);
  end

  // one sample request, valid stays high after acceptance until the next call
  task automatic send_sample(logic [22:0] s, logic neg, logic stop);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{sample_uv: s, sign_negative: neg, stop_window: stop};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // lower valid and let the block drain before a register write
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [22:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 23'($urandom_range(0, 2000));
      1: return 23'($urandom_range(4940000, 5000000));
      2: return 23'd5000000;
      3: return 23'($urandom_range(0, 1000000));
      4: return 23'($urandom_range(0, 23'h7FFFFF) % 5000001);
      default: return 23'($urandom_range(0, 5000000));
    endcase
  endfunction

  // field extremes and every range in dc mode
  task automatic test_range_extremes();
    write_reg(CFG_RATIO_HIGH, 24'hFFFFFF);
    write_reg(CFG_RATIO_MID, 24'h000000);
    for (int r = 0; r <= RANGE_R1K; r++) begin
      write_reg(CFG_RANGE_SELECT, 24'(r));
      send_sample(23'd0, 1'b1, 1'b0);
      send_sample(23'd5000000, 1'b0, 1'b1);
      settle();
    end
  endtask

  // auto-ranging, divider limits, bad codes and unknown indexes
  task automatic test_special_cases();
    write_reg(CFG_RANGE_SELECT, 24'(RANGE_MV800));
    send_sample(23'd500, 1'b0, 1'b0);
    send_sample(23'd5000000, 1'b1, 1'b0);
    send_sample(23'd4000000, 1'b0, 1'b0);
    settle();
    write_reg(CFG_RANGE_SELECT, 24'(RANGE_R1M));
    send_sample(23'd4950000, 1'b0, 1'b0);
    send_sample(23'd4949999, 1'b1, 1'b0);
    send_sample(23'd2500000, 1'b0, 1'b0);
    settle();
    write_reg(CFG_RANGE_SELECT, 24'd11);
    write_reg(CFG_RANGE_SELECT, 24'hFFFFFF);
    write_reg(4'd4, 24'h123456);
    write_reg(4'd15, 24'hFFFFFF);
    write_reg(CFG_AC_MODE, 24'd1);
    send_sample(23'd1000, 1'b1, 1'b0);
    send_sample(23'd1200, 1'b0, 1'b1);
    settle();
  endtask

  // ac peak over a full window and over short windows
  task automatic test_ac_window();
    write_reg(CFG_RANGE_SELECT, 24'(RANGE_A1));
    write_reg(CFG_AC_MODE, 24'd1);
    for (int i = 0; i < AcWindow; i++) send_sample(pick_sample(), 1'($urandom), 1'b0);
    send_sample(23'd7, 1'b0, 1'b1);
    settle();
    write_reg(CFG_AC_MODE, 24'd0);
    settle();
  endtask

  // random phases over random settings
  task automatic test_random_phases();
    logic [23:0] ratio;
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph != 5);
      case ($urandom_range(0, 3))
        0: ratio = 24'hFFFFFF;
        1: ratio = 24'h000000;
        default: ratio = 24'($urandom);
      endcase
      write_reg(CFG_RATIO_HIGH, ratio);
      write_reg(CFG_RATIO_MID, 24'($urandom));
      write_reg(CFG_RANGE_SELECT, 24'($urandom_range(0, 11)));
      write_reg(CFG_AC_MODE, 24'($urandom_range(0, 1)));
      for (int i = 0; i < 125; i++)
        send_sample(pick_sample(), 1'($urandom), $urandom_range(0, 14) == 0);
      settle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    sh_range_sel = RANGE_V200;
    sh_ac = 1'b0;
    sh_ratio_high = 24'd65536;
    sh_ratio_mid = 24'd65536;
    sh_cur_range = RANGE_V200;
    sh_peak = 0;
    sh_win_count = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_sample(23'd3000000, 1'b1, 1'b0);
    settle();
    test_range_extremes();
    test_special_cases();
    test_ac_window();
    test_random_phases();
    settle();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrvc_pkg.sv
rtl/core/mrvc_front.sv
rtl/core/mrvc_div.sv
rtl/core/mrvc_back.sv
rtl/core/meter_range_value_converter.sv
sim/meter_range_value_converter_tb.sv
